### src/spb_pkg.sv
// Shared types, op and status codes for the sprite blitter.
// No dependencies; imported by the controller, datapath and top module.
`default_nettype none
package spb_pkg;

  localparam int DEF_SCREEN_COLS = 320;
  localparam int DEF_SCREEN_ROWS = 240;
  localparam int DEF_CELL_SIDE   = 128;

  localparam logic [2:0] OP_UPLOAD_BEGIN = 3'd0;
  localparam logic [2:0] OP_UPLOAD_DATA  = 3'd1;
  localparam logic [2:0] OP_DRAW         = 3'd2;
  localparam logic [2:0] OP_CLEAR        = 3'd3;
  localparam logic [2:0] OP_READ_PIXEL   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NO_UPLOAD = 2'd3;

  localparam logic [2:0] SIZE_MAX = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] sprite_index;
    logic [7:0]  sprite_width;
    logic [7:0]  sprite_height;
    logic [31:0] data_word;
    logic [15:0] x_position;
    logic [15:0] y_position;
  } spb_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       pixel;
  } spb_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic begin_up;
    logic up_step;
    logic draw_set;
    logic draw_step;
    logic rd_issue;
    logic rd_grab;
    logic clr_step;
    logic post;
  } spb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic up_active;
    logic up_last;
    logic draw_none;
    logic draw_last;
    logic clr_last;
  } spb_stat_t;

  // Size code must be 0..4 and quadrant pairs above the used ones zero
  function automatic logic index_ok(input logic [12:0] idx);
    logic [2:0] s;
    logic       ok;
    s  = idx[12:10];
    ok = (s <= SIZE_MAX);
    for (int i = 1; i < 5; i++) begin
      if (3'(i) > s && idx[2*i +: 2] != 2'd0) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

### src/spb_ram.sv
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### src/spb_datapath.sv
// Datapath: item register, upload cursor, draw walker, clear sweep, both RAMs.
// Depends on spb_pkg and spb_ram.
`default_nettype none
module spb_datapath #(
  parameter int SCREEN_COLS = spb_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = spb_pkg::DEF_SCREEN_ROWS,
  parameter int CELL_SIDE   = spb_pkg::DEF_CELL_SIDE
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spb_pkg::spb_in_t   cmd,
  input  wire spb_pkg::spb_cmd_t  ctl,
  output spb_pkg::spb_stat_t      stat,
  output spb_pkg::spb_out_t       rsp
);
  import spb_pkg::*;

  localparam int FRAME_SIZE = SCREEN_COLS * SCREEN_ROWS;
  localparam int STORE_SIZE = 4 * CELL_SIDE * CELL_SIDE;
  localparam int SWEEP_N    = (FRAME_SIZE > STORE_SIZE) ? FRAME_SIZE : STORE_SIZE;
  localparam int FA_W = $clog2(FRAME_SIZE);
  localparam int SA_W = $clog2(STORE_SIZE);
  localparam int CW   = $clog2(SWEEP_N);
  localparam int SD_W = $clog2(CELL_SIDE + 1);
  localparam int XW   = $clog2(SCREEN_COLS + 1);
  localparam int YW   = $clog2(SCREEN_ROWS + 1);
  localparam int LW0  = (XW > YW) ? XW : YW;
  localparam int LW   = (LW0 > SD_W) ? LW0 : SD_W;

  // Offset of a cell: sum of quadrant selectors times shrinking quadrant sizes
  function automatic logic [SA_W-1:0] cell_off(input logic [12:0] idx);
    logic [SA_W:0] acc;
    logic [2:0]    s;
    acc = '0;
    s   = idx[12:10];
    for (int i = 0; i < 5; i++) begin
      if (3'(i) <= s)
        acc = acc + (SA_W+1)'(idx[2*i +: 2]) * (SA_W+1)'((CELL_SIDE * CELL_SIDE) >> (2*i));
    end
    return acc[SA_W-1:0];
  endfunction

  spb_in_t it;
  logic [1:0] code;
  logic       pix;
  logic       rd_in;

  // Upload state
  logic            up_active;
  logic [SA_W:0]   rowbase;
  logic [SD_W-1:0] pitch;
  logic [7:0]      cols, rows, ccol, crow;
  logic [4:0]      bcnt;

  // Draw state
  logic [LW-1:0]   limx, limy, dx, dy;
  logic [SD_W-1:0] dside;
  logic [SA_W-1:0] rsrc;
  logic [FA_W-1:0] rdst;
  logic            wr_pend;
  logic [FA_W-1:0] wr_addr;

  // Sweep state
  logic [CW-1:0] ccnt;
  logic          sweep_all;

  // RAM ports
  logic            fr_we, fr_wd, fr_q, sp_we, sp_wd, sp_q;
  logic [FA_W-1:0] fr_wa, fr_ra;
  logic [SA_W-1:0] sp_wa, sp_ra;

  // Combinational decode of the held item
  logic [2:0]      sz;
  logic [SD_W-1:0] side;
  logic            idx_ok, too_big, sz_bad;
  logic [SA_W-1:0] off;
  logic            x_in, y_in;
  logic [LW-1:0]   remx, remy, nlimx, nlimy;
  logic [SA_W:0]   up_dest;
  logic            col_end, up_end;
  logic            draw_row_end;
  logic [FA_W-1:0] rd_addr;

  always_comb begin
    sz      = it.sprite_index[12:10];
    sz_bad  = (sz > SIZE_MAX);
    side    = sz_bad ? SD_W'(1) : SD_W'(CELL_SIDE >> sz);
    idx_ok  = index_ok(it.sprite_index);
    too_big = (9'(it.sprite_width) > 9'(side)) || (9'(it.sprite_height) > 9'(side));
    off     = cell_off(it.sprite_index);
    x_in    = (it.x_position < 16'(SCREEN_COLS));
    y_in    = (it.y_position < 16'(SCREEN_ROWS));
    remx    = LW'(SCREEN_COLS) - LW'(it.x_position[XW-1:0]);
    remy    = LW'(SCREEN_ROWS) - LW'(it.y_position[YW-1:0]);
    nlimx   = !x_in ? '0 : ((remx < LW'(side)) ? remx : LW'(side));
    nlimy   = !y_in ? '0 : ((remy < LW'(side)) ? remy : LW'(side));
    up_dest = rowbase + (SA_W+1)'(ccol);
    col_end = (9'(ccol) + 9'd1 >= 9'(cols));
    up_end  = col_end && (9'(crow) + 9'd1 >= 9'(rows));
    draw_row_end = (dx == limx - LW'(1));
    rd_addr = FA_W'(FA_W'(it.y_position[YW-1:0]) * FA_W'(SCREEN_COLS))
            + FA_W'(it.x_position[XW-1:0]);
  end

  assign stat.up_active = up_active;
  assign stat.up_last   = (bcnt == 5'd31) || up_end;
  assign stat.draw_none = sz_bad || (nlimx == '0) || (nlimy == '0);
  assign stat.draw_last = draw_row_end && (dy == limy - LW'(1));
  assign stat.clr_last  = sweep_all ? (ccnt == CW'(SWEEP_N - 1)) : (ccnt == CW'(FRAME_SIZE - 1));

  // Item, result code and result register
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      it   <= cmd;
      code <= (cmd.op == OP_UPLOAD_DATA && !up_active) ? ST_NO_UPLOAD : ST_OK;
      pix  <= 1'b0;
    end
    if (ctl.begin_up) begin
      if (!idx_ok)      code <= ST_BAD_INDEX;
      else if (too_big) code <= ST_TOO_LARGE;
    end
    if (ctl.draw_set && sz_bad) code <= ST_BAD_INDEX;
    if (ctl.rd_issue) rd_in <= x_in && y_in;
    if (ctl.rd_grab)  pix   <= rd_in & fr_q;
    if (ctl.post) begin
      rsp.status <= code;
      rsp.pixel  <= pix;
    end
  end

  // Upload cursor: one sprite bit per step
  always_ff @(posedge clk) begin
    if (rst) begin
      up_active <= 1'b0;
    end else begin
      if (ctl.take) bcnt <= '0;
      if (ctl.begin_up && idx_ok && !too_big) begin
        rowbase   <= (SA_W+1)'(off);
        pitch     <= side;
        cols      <= it.sprite_width;
        rows      <= it.sprite_height;
        ccol      <= '0;
        crow      <= '0;
        up_active <= (it.sprite_width != 8'd0) && (it.sprite_height != 8'd0);
      end
      if (ctl.up_step) begin
        bcnt <= bcnt + 5'd1;
        if (col_end) begin
          ccol    <= '0;
          crow    <= crow + 8'd1;
          rowbase <= rowbase + (SA_W+1)'(pitch);
          if (up_end) up_active <= 1'b0;
        end else begin
          ccol <= ccol + 8'd1;
        end
      end
    end
  end

  // Draw walker: raster over the clipped cell, each write lands in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= ctl.draw_step;
      if (ctl.draw_set) begin
        limx  <= nlimx;
        limy  <= nlimy;
        dside <= side;
        dx    <= '0;
        dy    <= '0;
        rsrc  <= off;
        rdst  <= rd_addr;
      end
      if (ctl.draw_step) begin
        wr_addr <= rdst + FA_W'(dx);
        if (draw_row_end) begin
          dx   <= '0;
          dy   <= dy + LW'(1);
          rsrc <= rsrc + SA_W'(dside);
          rdst <= rdst + FA_W'(SCREEN_COLS);
        end else begin
          dx <= dx + LW'(1);
        end
      end
    end
  end

  // Clear sweep; after reset it also zeroes the sprite store
  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt      <= '0;
      sweep_all <= 1'b1;
    end else if (ctl.take && cmd.op == OP_CLEAR) begin
      ccnt      <= '0;
      sweep_all <= 1'b0;
    end else if (ctl.clr_step) begin
      ccnt <= ccnt + CW'(1);
    end
  end

  // RAM port muxing
  always_comb begin
    fr_we = wr_pend || (ctl.clr_step && ccnt < CW'(FRAME_SIZE));
    fr_wa = wr_pend ? wr_addr : FA_W'(ccnt);
    fr_wd = wr_pend ? (fr_q ^ sp_q) : 1'b0;
    fr_ra = ctl.draw_step ? (rdst + FA_W'(dx)) : rd_addr;
    sp_ra = rsrc + SA_W'(dx);
    if (ctl.up_step) begin
      sp_we = (up_dest < (SA_W+1)'(STORE_SIZE));
      sp_wa = up_dest[SA_W-1:0];
      sp_wd = it.data_word[5'd31 - bcnt];
    end else begin
      sp_we = ctl.clr_step && sweep_all && (ccnt < CW'(STORE_SIZE));
      sp_wa = SA_W'(ccnt);
      sp_wd = 1'b0;
    end
  end

  spb_ram #(.WIDTH(1), .DEPTH(FRAME_SIZE)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_q)
  );

  spb_ram #(.WIDTH(1), .DEPTH(STORE_SIZE)) u_store (
    .clk(clk), .we(sp_we), .waddr(sp_wa), .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_q)
  );
endmodule
`default_nettype wire

### src/spb_ctrl.sv
// Controller state machine: sequences each op and owns the result handshake.
// Depends on spb_pkg.
`default_nettype none
module spb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire logic [2:0]         op,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire spb_pkg::spb_stat_t stat,
  output spb_pkg::spb_cmd_t       ctl
);
  import spb_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_BEGIN, S_DATA, S_DRAW_SET, S_DRAW_RUN,
    S_DRAW_TAIL, S_RD_ADDR, S_RD_WAIT, S_POST
  } state_t;

  state_t state;
  logic   sweep_post;
  logic   accept;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // Decode commands from state
  always_comb begin
    ctl           = '0;
    ctl.take      = accept;
    ctl.begin_up  = (state == S_BEGIN);
    ctl.up_step   = (state == S_DATA);
    ctl.draw_set  = (state == S_DRAW_SET);
    ctl.draw_step = (state == S_DRAW_RUN);
    ctl.rd_issue  = (state == S_RD_ADDR);
    ctl.rd_grab   = (state == S_RD_WAIT);
    ctl.clr_step  = (state == S_SWEEP);
    ctl.post      = (state == S_POST) && (!rsp_valid || rsp_ready);
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_post <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (ctl.post) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_SWEEP: begin
          if (stat.clr_last) state <= sweep_post ? S_POST : S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_UPLOAD_BEGIN: state <= S_BEGIN;
              OP_UPLOAD_DATA:  state <= stat.up_active ? S_DATA : S_POST;
              OP_DRAW:         state <= S_DRAW_SET;
              OP_CLEAR: begin
                state      <= S_SWEEP;
                sweep_post <= 1'b1;
              end
              OP_READ_PIXEL:   state <= S_RD_ADDR;
              default:         state <= S_POST;
            endcase
          end
        end
        S_BEGIN:     state <= S_POST;
        S_DATA:      if (stat.up_last) state <= S_POST;
        S_DRAW_SET:  state <= stat.draw_none ? S_POST : S_DRAW_RUN;
        S_DRAW_RUN:  if (stat.draw_last) state <= S_DRAW_TAIL;
        S_DRAW_TAIL: state <= S_POST;
        S_RD_ADDR:   state <= S_RD_WAIT;
        S_RD_WAIT:   state <= S_POST;
        S_POST: begin
          if (ctl.post) state <= S_IDLE;
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.post |-> (!rsp_valid || rsp_ready)) else $error("result overwritten");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd_ready) else $error("ready after accept");
  a_rsp_from_post: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_POST) else $error("result outside post");
`endif
endmodule
`default_nettype wire

### src/sprite_blitter_xor_framebuffer.sv
// One-bit sprite blitter with an XOR frame buffer.
// Channels: cmd (valid/ready, spb_in_t) carries one op per beat; rsp
// (valid/ready, spb_out_t) returns exactly one status/pixel beat per op.
// One op is worked at a time; cmd_ready is high only when the controller
// is idle. A finished result sits in the output register, so the next op
// can be taken while the receiver stalls; that op's own result waits in
// its post state until the register frees.
// Work per op:
//   upload_begin checks index and size; upload_data writes one sprite bit
//   per cycle; draw XORs clipped width * clipped height pixels, one pixel per
//   cycle through the frame RAM read-modify-write; clear zeroes the frame,
//   one frame bit per cycle; read_pixel returns one bit; other codes a status.
// Reset: a clearing pass zeroes frame and sprite store, one bit of each
// per cycle; cmd_ready stays low until it ends. The upload-active flag
// is cleared at reset.
// Depends on spb_pkg, spb_ctrl, spb_datapath.
`default_nettype none
module sprite_blitter_xor_framebuffer #(
  parameter int SCREEN_COLS = spb_pkg::DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = spb_pkg::DEF_SCREEN_ROWS,
  parameter int CELL_SIDE   = spb_pkg::DEF_CELL_SIDE
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire spb_pkg::spb_in_t cmd,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output spb_pkg::spb_out_t     rsp
);
  import spb_pkg::*;

  spb_cmd_t  ctl;
  spb_stat_t stat;

  spb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .op(cmd.op), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .stat(stat), .ctl(ctl)
  );

  spb_datapath #(
    .SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS), .CELL_SIDE(CELL_SIDE)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .ctl(ctl), .stat(stat), .rsp(rsp)
  );
endmodule
`default_nettype wire
